/* rtl/segment_band_statistics_core_assert.svh */
// assertion macros for the checker file of segment_band_statistics_core
// the enclosing scope provides clk and rst_n
`ifndef SEGMENT_BAND_STATISTICS_CORE_ASSERT_SVH
`define SEGMENT_BAND_STATISTICS_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SBS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbs check failed");

// consequent checked in the cycle after the antecedent
`define SBS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbs check failed");

`endif

/* rtl/sbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_pkg
// shared widths, entry layout and codes of the segment band statistics core
// ----------------------------------------------------------------------------
package sbs_pkg;

    localparam int LABELS      = 1024;
    localparam int BANDS       = 4;
    localparam int COUNT_WIDTH = 24;

    localparam int ADDR_W      = (LABELS > 1) ? $clog2(LABELS) : 1;
    localparam int LABEL_W     = 11;
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 40;
    localparam int IN_BANDS    = 4;
    localparam int OUT_COUNT_W = 24;

    typedef logic [IN_BANDS-1:0][SAMPLE_W-1:0] samples_t;

    typedef struct packed {
        logic [BANDS-1:0][SUM_W-1:0] sums;
        logic [COUNT_WIDTH-1:0]      count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [0:0] {
        OP_ACCUMULATE = 1'b0,
        OP_READ       = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        REG_LABELS_IN_USE = 1'b0,
        REG_BANDS_IN_USE  = 1'b1
    } cfg_index_t;

endpackage

/* rtl/sbs_entry_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_entry_ram
// one entry per label: pixel count and band sums, registered read port
// ----------------------------------------------------------------------------
module sbs_entry_ram
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [sbs_pkg::ADDR_W-1:0] waddr,
    input  sbs_pkg::entry_t          wdata,
    input  logic                     re,
    input  logic [sbs_pkg::ADDR_W-1:0] raddr,
    output sbs_pkg::entry_t          rdata
);

    sbs_pkg::entry_t mem [sbs_pkg::LABELS];
    sbs_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sbs_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_update
// saturating count increment and saturating sum update of the bands in use of one entry
// ----------------------------------------------------------------------------
module sbs_update
(
    input  sbs_pkg::entry_t   old_entry,
    input  sbs_pkg::samples_t samples,
    input  logic [2:0]        bands_in_use,
    output sbs_pkg::entry_t   new_entry
);

    assign new_entry.count = (&old_entry.count) ? old_entry.count
                                                : old_entry.count + 1'b1;

    for (genvar b = 0; b < sbs_pkg::BANDS; b++)
    begin : g_band
        if (b < sbs_pkg::IN_BANDS)
        begin : g_add
            logic [sbs_pkg::SUM_W:0] wide_sum;
            logic [sbs_pkg::SUM_W-1:0] sat_sum;

            assign wide_sum = {old_entry.sums[b][sbs_pkg::SUM_W-1], old_entry.sums[b]}
                + {{(sbs_pkg::SUM_W + 1 - sbs_pkg::SAMPLE_W){samples[b][sbs_pkg::SAMPLE_W-1]}},
                   samples[b]};

            // overflow when the two top bits disagree; clamp toward the true sign
            always_comb
            begin
                if (wide_sum[sbs_pkg::SUM_W] != wide_sum[sbs_pkg::SUM_W-1])
                begin
                    sat_sum = {wide_sum[sbs_pkg::SUM_W],
                               {(sbs_pkg::SUM_W-1){~wide_sum[sbs_pkg::SUM_W]}}};
                end
                else
                begin
                    sat_sum = wide_sum[sbs_pkg::SUM_W-1:0];
                end
            end

            assign new_entry.sums[b] = (3'(b) < bands_in_use) ? sat_sum
                                                              : old_entry.sums[b];
        end
        else
        begin : g_keep
            assign new_entry.sums[b] = old_entry.sums[b];
        end
    end

endmodule

/* rtl/segment_band_statistics_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_band_statistics_core
// per-label pixel count and band sum accumulator with read-back
// ----------------------------------------------------------------------------
//  channel   direction  transaction
//  s_axis    in         one pixel to accumulate or one label to read
//  m_axis    out        chunk done marker or one label's statistics
//  cfg       in         write of labels_in_use or bands_in_use
//
//  one item per cycle: the label entry is read as the item enters s1, then
//  updated in s1 and written back; a write-back register forwards into a
//  following read of the same label. results pass from s1 into the output
//  register. after reset the entry memory is cleared one label per cycle,
//  with s_axis_tready low; cfg writes are taken meanwhile. a result waiting
//  in the output register stalls only items that give one.
// ----------------------------------------------------------------------------
module segment_band_statistics_core
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // operation[0], label[11:1], band_zero[27:12], band_one[43:28],
    // band_two[59:44], band_three[75:60], zero[79:76]
    input  logic [79:0]              s_axis_tdata,
    input  logic                     s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // pixel_count[23:0], sum_zero[63:24], sum_one[103:64],
    // sum_two[143:104], sum_three[183:144]
    output logic [183:0]             m_axis_tdata,
    // chunk_done[0]
    output logic                     m_axis_tuser,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  sbs_pkg::cfg_index_t      cfg_index,
    input  logic [10:0]              cfg_data
);

    // configuration
    logic [sbs_pkg::LABEL_W-1:0] labels_reg;
    logic [2:0]                  bands_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            labels_reg <= 11'd1024;
            bands_reg  <= 3'd4;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sbs_pkg::REG_LABELS_IN_USE: labels_reg <= cfg_data;
                sbs_pkg::REG_BANDS_IN_USE:  bands_reg  <= cfg_data[2:0];
                default:                    labels_reg <= labels_reg;
            endcase
        end
    end

    // input fields
    sbs_pkg::op_t                in_op;
    logic [sbs_pkg::LABEL_W-1:0] in_label;
    sbs_pkg::samples_t           in_samples;
    logic                        in_label_ok;

    assign in_op      = sbs_pkg::op_t'(s_axis_tdata[0]);
    assign in_label   = s_axis_tdata[11:1];
    assign in_samples = s_axis_tdata[75:12];
    assign in_label_ok = (in_label != '0) && (in_label <= labels_reg)
                      && (32'(in_label) <= sbs_pkg::LABELS);

    // clearing pass
    logic                       clearing_reg;
    logic [sbs_pkg::ADDR_W-1:0] clear_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == sbs_pkg::ADDR_W'(sbs_pkg::LABELS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // pipeline registers
    logic                       s1_valid_reg;
    sbs_pkg::op_t               s1_op_reg;
    logic                       s1_label_ok_reg;
    logic                       s1_last_reg;
    logic [sbs_pkg::ADDR_W-1:0] s1_addr_reg;
    sbs_pkg::samples_t          s1_samples_reg;

    logic                       wb_valid_reg;
    logic [sbs_pkg::ADDR_W-1:0] wb_addr_reg;
    sbs_pkg::entry_t            wb_data_reg;

    logic                       out_valid_reg;
    logic                       out_done_reg;
    logic [183:0]               out_data_reg;

    logic                       in_accept;
    logic                       s1_has_result;
    logic                       out_free;
    logic                       s1_go;
    logic                       s1_write;
    sbs_pkg::entry_t            ram_rdata;
    sbs_pkg::entry_t            merged;
    sbs_pkg::entry_t            updated;
    logic                       ram_we;
    logic [sbs_pkg::ADDR_W-1:0] ram_waddr;
    sbs_pkg::entry_t            ram_wdata;
    logic [183:0]               read_payload;

    assign s1_has_result = (s1_op_reg == sbs_pkg::OP_READ) || s1_last_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_go         = s1_valid_reg && (!s1_has_result || out_free);
    assign s_axis_tready = !clearing_reg && (!s1_valid_reg || s1_go);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s1_write      = s1_go && (s1_op_reg == sbs_pkg::OP_ACCUMULATE) && s1_label_ok_reg;

    // the entry written on the edge of our read is stale in the ram
    assign merged = (wb_valid_reg && (wb_addr_reg == s1_addr_reg)) ? wb_data_reg : ram_rdata;

    sbs_update u_update
    (
        .old_entry    (merged),
        .samples      (s1_samples_reg),
        .bands_in_use (bands_reg),
        .new_entry    (updated)
    );

    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s1_write;
            ram_waddr = s1_addr_reg;
            ram_wdata = updated;
        end
    end

    sbs_entry_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (sbs_pkg::ADDR_W'(in_label - 1'b1)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        read_payload        = '0;
        read_payload[23:0]  = sbs_pkg::OUT_COUNT_W'(merged.count);
        for (int b = 0; b < sbs_pkg::IN_BANDS; b++)
        begin
            if (b < sbs_pkg::BANDS)
            begin
                read_payload[24 + b*sbs_pkg::SUM_W +: sbs_pkg::SUM_W] =
                    merged.sums[b % sbs_pkg::BANDS];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_write)
            begin
                wb_valid_reg <= 1'b1;
            end

            if (s1_go && s1_has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg       <= in_op;
            s1_label_ok_reg <= in_label_ok;
            s1_last_reg     <= s_axis_tlast;
            s1_addr_reg     <= sbs_pkg::ADDR_W'(in_label - 1'b1);
            s1_samples_reg  <= in_samples;
        end
        if (s1_write)
        begin
            wb_addr_reg <= s1_addr_reg;
            wb_data_reg <= updated;
        end
        if (s1_go && s1_has_result)
        begin
            out_done_reg <= (s1_op_reg == sbs_pkg::OP_ACCUMULATE);
            out_data_reg <= ((s1_op_reg == sbs_pkg::OP_READ) && s1_label_ok_reg)
                            ? read_payload : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_done_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* rtl/sbs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_checker
// port-level checks of segment_band_statistics_core, bound to the top level
// ----------------------------------------------------------------------------
`include "segment_band_statistics_core_assert.svh"

module sbs_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [79:0]  s_axis_tdata,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [183:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    // a stalled result stays offered
    `SBS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // a chunk done result carries no statistics
    `SBS_ASSERT_NOW(a_done_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)

    // a result is offered after the last pixel of a chunk is accepted
    `SBS_ASSERT_NEXT(a_last_gives_result,
        s_axis_tvalid && s_axis_tready && s_axis_tlast && !s_axis_tdata[0],
        ##1 m_axis_tvalid)

endmodule

bind segment_band_statistics_core sbs_checker u_sbs_checker (.*);

/* sim/segment_band_statistics_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_band_statistics_core_test
// streams pixels and label reads into the core under several register
// settings, keeps its own per-label count and band sum store to predict
// every chunk done marker and read-back, and checks each output
// transaction in order against the oldest prediction
// ----------------------------------------------------------------------------
module segment_band_statistics_core_test;

    localparam int CLK_HALF         = 4;
    localparam int SETTLE_CYCLES    = 4;
    localparam int HOLD_CYCLES      = 400;
    localparam int RANDOM_PER_PHASE = 180;
    localparam int PRESSURE_ITEMS   = 250;
    localparam int RUN_LIMIT_NS     = 2_000_000;

    localparam logic signed [sbs_pkg::SUM_W:0] SUM_HI = 41'sd549755813887;
    localparam logic signed [sbs_pkg::SUM_W:0] SUM_LO = -41'sd549755813888;

    typedef struct packed {
        logic                                             done;
        logic [sbs_pkg::OUT_COUNT_W-1:0]                  count;
        logic [sbs_pkg::IN_BANDS-1:0][sbs_pkg::SUM_W-1:0] sums;
    } stats_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [79:0]         s_axis_tdata;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [183:0]        m_axis_tdata;
    logic                m_axis_tuser;
    logic                cfg_valid;
    logic                cfg_ready;
    sbs_pkg::cfg_index_t cfg_index;
    logic [10:0]         cfg_data;

    // predicted store and register copies
    logic [sbs_pkg::COUNT_WIDTH-1:0]  label_count [sbs_pkg::LABELS];
    logic signed [sbs_pkg::SUM_W-1:0] band_sum [sbs_pkg::BANDS][sbs_pkg::LABELS];
    logic [sbs_pkg::LABEL_W-1:0]      labels_limit;
    logic [2:0]                       bands_limit;
    stats_t                           expected_stats [$];

    int   error_count;
    int   burst_left;
    logic hold_req;

    segment_band_statistics_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= 100)
        begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endtask

    function automatic void clear_store();
        int l;
        int b;
        for (l = 0; l < sbs_pkg::LABELS; l++)
        begin
            label_count[l] = '0;
            for (b = 0; b < sbs_pkg::BANDS; b++)
            begin
                band_sum[b][l] = '0;
            end
        end
        labels_limit = 11'd1024;
        bands_limit  = 3'd4;
    endfunction

    // updates the store for one accepted item and queues the result it causes
    function automatic void accumulate_or_read(sbs_pkg::op_t op,
                                               logic [sbs_pkg::LABEL_W-1:0] label,
                                               sbs_pkg::samples_t s, logic last);
        stats_t                              r;
        logic                                hit;
        int                                  idx;
        int                                  b;
        logic signed [sbs_pkg::SUM_W:0]      t;
        logic signed [sbs_pkg::SAMPLE_W-1:0] v;
        r   = '0;
        hit = (label != 0) && (label <= labels_limit) && (label <= sbs_pkg::LABELS);
        idx = int'(label) - 1;
        if (op == sbs_pkg::OP_ACCUMULATE)
        begin
            if (hit)
            begin
                if (label_count[idx] != '1)
                begin
                    label_count[idx] = label_count[idx] + 1'b1;
                end
                for (b = 0; b < sbs_pkg::IN_BANDS && b < sbs_pkg::BANDS
                            && b < int'(bands_limit); b++)
                begin
                    v = s[b];
                    t = band_sum[b][idx] + v;
                    if (t > SUM_HI)
                    begin
                        t = SUM_HI;
                    end
                    else if (t < SUM_LO)
                    begin
                        t = SUM_LO;
                    end
                    band_sum[b][idx] = t[sbs_pkg::SUM_W-1:0];
                end
            end
            if (last)
            begin
                r.done = 1'b1;
                expected_stats.push_back(r);
            end
        end
        else
        begin
            if (hit)
            begin
                r.count = label_count[idx];
                for (b = 0; b < sbs_pkg::IN_BANDS && b < sbs_pkg::BANDS; b++)
                begin
                    r.sums[b] = band_sum[b][idx];
                end
            end
            expected_stats.push_back(r);
        end
    endfunction

    task automatic check_result(logic user, logic [183:0] data);
        stats_t want;
        int     b;
        if (expected_stats.size() == 0)
        begin
            report_mismatch("result arrived with nothing expected");
            return;
        end
        want = expected_stats.pop_front();
        if (user !== want.done)
        begin
            report_mismatch($sformatf("chunk_done got %0b expected %0b", user, want.done));
        end
        if (data[sbs_pkg::OUT_COUNT_W-1:0] !== want.count)
        begin
            report_mismatch($sformatf("pixel_count got %0d expected %0d",
                                      data[sbs_pkg::OUT_COUNT_W-1:0], want.count));
        end
        for (b = 0; b < sbs_pkg::IN_BANDS; b++)
        begin
            if (data[sbs_pkg::OUT_COUNT_W + sbs_pkg::SUM_W*b +: sbs_pkg::SUM_W]
                !== want.sums[b])
            begin
                report_mismatch($sformatf("sum of band %0d got %0d expected %0d", b,
                    $signed(data[sbs_pkg::OUT_COUNT_W + sbs_pkg::SUM_W*b +: sbs_pkg::SUM_W]),
                    $signed(want.sums[b])));
            end
        end
    endtask

    // result side: checks each output transaction, then picks the next tready
    initial
    begin : result_side
        int   cyc;
        int   stall_left;
        logic go;
        cyc        = 0;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                check_result(m_axis_tuser, m_axis_tdata);
            end
            if (hold_req)
            begin
                stall_left = HOLD_CYCLES;
            end
            case ((cyc / 97) % 4)
                0:       go = 1'b1;
                1:       go = 1'($urandom_range(0, 1));
                2:       go = (cyc % 5) != 0;
                default: go = $urandom_range(0, 4) == 0;
            endcase
            if (stall_left > 0)
            begin
                go = 1'b0;
                stall_left--;
            end
            m_axis_tready <= go;
            cyc++;
        end
    end

    task automatic send_item(sbs_pkg::op_t op, logic [sbs_pkg::LABEL_W-1:0] label,
                             sbs_pkg::samples_t s, logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, s, label, op};
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        accumulate_or_read(op, label, s, last);
    endtask

    task automatic idle(int n);
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // waits until every predicted result is back, then lets the pipe empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_stats.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(sbs_pkg::cfg_index_t which, logic [10:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (which == sbs_pkg::REG_LABELS_IN_USE)
        begin
            labels_limit = value;
        end
        else
        begin
            bands_limit = value[2:0];
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [sbs_pkg::LABEL_W-1:0] pick_label();
        int pick;
        case ($urandom_range(0, 9))
            0:       pick = 0;
            1:       pick = int'($urandom_range(0, 2047));
            2, 3:    pick = int'(labels_limit) + int'($urandom_range(0, 4)) - 2;
            default: pick = int'($urandom_range(1, 12));
        endcase
        if (pick < 0)
        begin
            pick = 0;
        end
        if (pick > 2047)
        begin
            pick = 2047;
        end
        return pick[sbs_pkg::LABEL_W-1:0];
    endfunction

    function automatic logic [sbs_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_item();
        sbs_pkg::samples_t s;
        sbs_pkg::op_t      op;
        int                b;
        for (b = 0; b < sbs_pkg::IN_BANDS; b++)
        begin
            s[b] = pick_sample();
        end
        op = ($urandom_range(0, 9) < 6) ? sbs_pkg::OP_ACCUMULATE : sbs_pkg::OP_READ;
        send_item(op, pick_label(), s, $urandom_range(0, 3) == 0);
    endtask

    // bursts of random length with random gaps, some gaps of zero
    task automatic pace();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        end
        burst_left--;
    endtask

    task automatic test_directed_extremes();
        sbs_pkg::samples_t hi;
        sbs_pkg::samples_t lo;
        sbs_pkg::samples_t mix;
        hi  = {4{16'h7fff}};
        lo  = {4{16'h8000}};
        mix = {16'hffff, 16'h0001, 16'h8000, 16'h7fff};
        send_item(sbs_pkg::OP_READ, 11'd1, hi, 1'b0);
        send_item(sbs_pkg::OP_ACCUMULATE, 11'd1, hi, 1'b0);
        send_item(sbs_pkg::OP_ACCUMULATE, 11'd1, lo, 1'b1);
        send_item(sbs_pkg::OP_ACCUMULATE, 11'd1024, mix, 1'b0);
        // unlabelled and out of range pixels that end a chunk still give a done marker
        send_item(sbs_pkg::OP_ACCUMULATE, 11'd0, hi, 1'b1);
        send_item(sbs_pkg::OP_ACCUMULATE, 11'd1025, hi, 1'b0);
        send_item(sbs_pkg::OP_ACCUMULATE, 11'd2047, lo, 1'b1);
        send_item(sbs_pkg::OP_READ, 11'd1, '0, 1'b0);
        send_item(sbs_pkg::OP_READ, 11'd1024, '0, 1'b1);
        send_item(sbs_pkg::OP_READ, 11'd0, '0, 1'b0);
        send_item(sbs_pkg::OP_READ, 11'd1025, '0, 1'b0);
        send_item(sbs_pkg::OP_READ, 11'd2047, '0, 1'b0);
        // same label back to back exercises the write-back forwarding
        repeat (3) send_item(sbs_pkg::OP_ACCUMULATE, 11'd3, mix, 1'b0);
        send_item(sbs_pkg::OP_READ, 11'd3, '0, 1'b0);
        send_item(sbs_pkg::OP_ACCUMULATE, 11'd1024, hi, 1'b0);
        send_item(sbs_pkg::OP_READ, 11'd1024, '0, 1'b0);
        settle();
    endtask

    task automatic test_register_ranges();
        sbs_pkg::samples_t hi;
        sbs_pkg::samples_t mix;
        hi  = {4{16'h7fff}};
        mix = {16'hffff, 16'h0001, 16'h8000, 16'h7fff};
        write_reg(sbs_pkg::REG_BANDS_IN_USE, 11'd0);
        send_item(sbs_pkg::OP_ACCUMULATE, 11'd2, hi, 1'b0);
        send_item(sbs_pkg::OP_READ, 11'd2, '0, 1'b0);
        write_reg(sbs_pkg::REG_LABELS_IN_USE, 11'd0);
        send_item(sbs_pkg::OP_ACCUMULATE, 11'd2, hi, 1'b1);
        send_item(sbs_pkg::OP_READ, 11'd2, '0, 1'b0);
        write_reg(sbs_pkg::REG_LABELS_IN_USE, 11'd2047);
        write_reg(sbs_pkg::REG_BANDS_IN_USE, 11'd7);
        send_item(sbs_pkg::OP_ACCUMULATE, 11'd1024, mix, 1'b0);
        send_item(sbs_pkg::OP_ACCUMULATE, 11'd1025, mix, 1'b0);
        send_item(sbs_pkg::OP_READ, 11'd1024, '0, 1'b0);
        write_reg(sbs_pkg::REG_LABELS_IN_USE, 11'd1);
        write_reg(sbs_pkg::REG_BANDS_IN_USE, 11'd1);
        send_item(sbs_pkg::OP_ACCUMULATE, 11'd1, mix, 1'b0);
        send_item(sbs_pkg::OP_ACCUMULATE, 11'd2, mix, 1'b0);
        send_item(sbs_pkg::OP_READ, 11'd1, '0, 1'b0);
        send_item(sbs_pkg::OP_READ, 11'd2, '0, 1'b0);
        settle();
    endtask

    task automatic test_random_traffic();
        int          phase;
        int          i;
        logic [10:0] lab;
        logic [10:0] bnd;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       begin lab = 11'd1024; bnd = 11'd4;     end
                1:       begin lab = 11'd12;   bnd = 11'd2;     end
                // only the low three data bits count for the band register
                2:       begin lab = 11'd2047; bnd = 11'h7fb;   end
                3:       begin lab = 11'd1;    bnd = 11'd3;     end
                4:       begin lab = 11'd0;    bnd = 11'd4;     end
                5:       begin lab = 11'd600;  bnd = 11'd0;     end
                6:       begin lab = 11'd1024; bnd = 11'd1;     end
                default:
                begin
                    lab = 11'($urandom_range(1, 2047));
                    bnd = 11'($urandom_range(0, 7));
                end
            endcase
            write_reg(sbs_pkg::REG_LABELS_IN_USE, lab);
            write_reg(sbs_pkg::REG_BANDS_IN_USE, bnd);
            burst_left = 0;
            for (i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                if (i == RANDOM_PER_PHASE / 2)
                begin
                    settle();
                end
                pace();
                send_random_item();
            end
        end
        settle();
    endtask

    // output held off for a long stretch while input is offered at full rate until the core stalls it
    task automatic test_backpressure();
        int i;
        write_reg(sbs_pkg::REG_LABELS_IN_USE, 11'd1024);
        write_reg(sbs_pkg::REG_BANDS_IN_USE, 11'd4);
        hold_req <= 1'b1;
        send_random_item();
        hold_req <= 1'b0;
        for (i = 1; i < PRESSURE_ITEMS; i++)
        begin
            send_random_item();
        end
        settle();
    endtask

    initial
    begin
        error_count = 0;
        burst_left  = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= sbs_pkg::REG_LABELS_IN_USE;
        cfg_data      <= '0;
        hold_req      <= 1'b0;
        clear_store();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_register_ranges();
        test_random_traffic();
        test_backpressure();

        settle();
        repeat (8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
